@@ sv/cct_pkg.sv @@
package cct_pkg;

	localparam logic       OP_TICK = 1'b0;
	localparam logic       OP_LOAD = 1'b1;

	localparam logic [5:0] LAST_SECOND  = 6'd59;
	localparam logic [5:0] LAST_MINUTE  = 6'd59;
	localparam logic [4:0] LAST_HOUR    = 5'd23;
	localparam logic [2:0] LAST_WEEKDAY = 3'd7;
	localparam logic [3:0] LAST_MONTH   = 4'd12;
	localparam logic [4:0] NOON_HOUR    = 5'd12;

	// 25 * INV25 == 1 modulo 2**16; a multiple of 25 maps to no more than 65535 / 25
	localparam logic [15:0] INV25     = 16'h5C29;
	localparam logic [15:0] DIV25_MAX = 16'd2621;

	function automatic logic is_leap(input logic [15:0] y);
		logic [15:0] r;
		logic        div4;
		logic        div16;
		logic        div25;
		r     = y * INV25;
		div4  = (y[1:0] == 2'd0);
		div16 = (y[3:0] == 4'd0);
		div25 = (r <= DIV25_MAX);
		return div4 & (!div25 | div16);
	endfunction

	// invalid months count as 31 days long
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2:                   len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ sv/calendar_clock_tick.sv @@
// Real-time clock calendar. Each input word is a one-second tick or a load of a full
// date and time (operation selects); each word returns one output word with the full
// time after it. An input word is registered, then applied to the calendar registers,
// which also drive the output ports, so one word is taken every cycle while the output
// is not stalled. The leap flag of the following year is kept ready in a register, so
// the year rollover does not hold up the flow. Loaded values are stored as given, even out
// of range; after reset the calendar reads year 0, January 1, 00:00:00, weekday 1.
module calendar_clock_tick import cct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [15:0] set_year,
	input  logic [3:0]  set_month,
	input  logic [4:0]  set_day,
	input  logic [4:0]  set_hours,
	input  logic [5:0]  set_minutes,
	input  logic [5:0]  set_seconds,
	input  logic [2:0]  set_weekday,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] year_now,
	output logic [3:0]  month_now,
	output logic [4:0]  day_now,
	output logic [4:0]  hours_now,
	output logic [5:0]  minutes_now,
	output logic [5:0]  seconds_now,
	output logic [2:0]  weekday_now,
	output logic        pm_flag,
	output logic        leap_flag
);

	logic        valid_s1;
	logic        op_s1;
	logic [15:0] year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [4:0]  hours_s1;
	logic [5:0]  minutes_s1;
	logic [5:0]  seconds_s1;
	logic [2:0]  weekday_s1;
	logic        leap_s1;
	logic        leap_nx_s1;

	logic [15:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [4:0]  hours_q;
	logic [5:0]  minutes_q;
	logic [5:0]  seconds_q;
	logic [2:0]  weekday_q;
	logic        leap_q;
	logic        leap_nx_q;
	logic        out_valid_q;

	logic accept;
	logic commit;

	logic [15:0] year_d;
	logic [3:0]  month_d;
	logic [4:0]  day_d;
	logic [4:0]  hours_d;
	logic [5:0]  minutes_d;
	logic [5:0]  seconds_d;
	logic [2:0]  weekday_d;
	logic        leap_d;
	logic        year_step;

	assign commit   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	// leap flags of the loaded year and the one after it are worked out on entry
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= operation;
			year_s1    <= set_year;
			month_s1   <= set_month;
			day_s1     <= set_day;
			hours_s1   <= set_hours;
			minutes_s1 <= set_minutes;
			seconds_s1 <= set_seconds;
			weekday_s1 <= set_weekday;
			leap_s1    <= is_leap(set_year);
			leap_nx_s1 <= is_leap(set_year + 16'd1);
		end
	end

	always_comb begin
		logic sec_wrap;
		logic min_wrap;
		logic hour_wrap;
		logic day_wrap;
		logic mon_wrap;
		sec_wrap  = (seconds_q >= LAST_SECOND);
		min_wrap  = (minutes_q >= LAST_MINUTE);
		hour_wrap = (hours_q >= LAST_HOUR);
		day_wrap  = ({1'b0, day_q} + 6'd1) > {1'b0, month_days(month_q, leap_q)};
		mon_wrap  = (month_q >= LAST_MONTH);

		year_d    = year_q;
		month_d   = month_q;
		day_d     = day_q;
		hours_d   = hours_q;
		minutes_d = minutes_q;
		seconds_d = seconds_q;
		weekday_d = weekday_q;
		leap_d    = leap_q;
		year_step = 1'b0;

		if (op_s1 == OP_LOAD) begin
			year_d    = year_s1;
			month_d   = month_s1;
			day_d     = day_s1;
			hours_d   = hours_s1;
			minutes_d = minutes_s1;
			seconds_d = seconds_s1;
			weekday_d = weekday_s1;
			leap_d    = leap_s1;
		end else if (!sec_wrap) begin
			seconds_d = seconds_q + 6'd1;
		end else begin
			seconds_d = 6'd0;
			if (!min_wrap) begin
				minutes_d = minutes_q + 6'd1;
			end else begin
				minutes_d = 6'd0;
				if (!hour_wrap) begin
					hours_d = hours_q + 5'd1;
				end else begin
					hours_d   = 5'd0;
					weekday_d = (weekday_q >= LAST_WEEKDAY) ? 3'd1 : weekday_q + 3'd1;
					if (!day_wrap) begin
						day_d = day_q + 5'd1;
					end else begin
						day_d = 5'd1;
						if (!mon_wrap) begin
							month_d = month_q + 4'd1;
						end else begin
							month_d   = 4'd1;
							year_d    = year_q + 16'd1;
							leap_d    = leap_nx_q;
							year_step = 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q      <= 16'd0;
			month_q     <= 4'd1;
			day_q       <= 5'd1;
			hours_q     <= 5'd0;
			minutes_q   <= 6'd0;
			seconds_q   <= 6'd0;
			weekday_q   <= 3'd1;
			leap_q      <= 1'b1;
			leap_nx_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				year_q    <= year_d;
				month_q   <= month_d;
				day_q     <= day_d;
				hours_q   <= hours_d;
				minutes_q <= minutes_d;
				seconds_q <= seconds_d;
				weekday_q <= weekday_d;
				leap_q    <= leap_d;
			end
			// refresh the next-year flag; a load brings its own
			if (commit && op_s1 == OP_LOAD) begin
				leap_nx_q <= leap_nx_s1;
			end else if (!(commit && year_step)) begin
				leap_nx_q <= is_leap(year_q + 16'd1);
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign year_now    = year_q;
	assign month_now   = month_q;
	assign day_now     = day_q;
	assign hours_now   = hours_q;
	assign minutes_now = minutes_q;
	assign seconds_now = seconds_q;
	assign weekday_now = weekday_q;
	assign pm_flag     = (hours_q >= NOON_HOUR);
	assign leap_flag   = leap_q;

	a_hold_time: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(seconds_now) && $stable(year_now) && $stable(day_now))
		else $error("calendar changed without a word");

	a_second_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit && op_s1 == OP_TICK && seconds_q < 6'd58
		|=> seconds_now == $past(seconds_now) + 6'd1 && $stable(minutes_now))
		else $error("tick did not advance seconds");

	a_new_year: assert property (@(posedge clk) disable iff (!arst_n)
		commit && op_s1 == OP_TICK |=> $stable(year_now)
		|| (month_now == 4'd1 && day_now == 5'd1 && hours_now == 5'd0
		&& minutes_now == 6'd0 && seconds_now == 6'd0))
		else $error("year changed away from new year midnight");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with room to spare");

endmodule

@@ tb/calendar_clock_tick_checker.sv @@
module calendar_clock_tick_checker import cct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        operation,
	input  logic [15:0] set_year,
	input  logic [3:0]  set_month,
	input  logic [4:0]  set_day,
	input  logic [4:0]  set_hours,
	input  logic [5:0]  set_minutes,
	input  logic [5:0]  set_seconds,
	input  logic [2:0]  set_weekday,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] year_now,
	input  logic [3:0]  month_now,
	input  logic [4:0]  day_now,
	input  logic [4:0]  hours_now,
	input  logic [5:0]  minutes_now,
	input  logic [5:0]  seconds_now,
	input  logic [2:0]  weekday_now,
	input  logic        pm_flag,
	input  logic        leap_flag,
	output int          mismatch_count,
	output int          words_outstanding,
	output int          words_checked
);

	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [2:0]  weekday;
		logic        pm;
		logic        leap;
	} calendar_reading_t;

	localparam int MAX_REPORTED = 20;
	localparam logic [4:0] COMMON_YEAR_DAYS [1:12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	calendar_reading_t clock_state;
	calendar_reading_t expected_words[$];

	function automatic logic gregorian_leap(input logic [15:0] y);
		return ((y % 400) == 0) || (((y % 100) != 0) && ((y % 4) == 0));
	endfunction

	// months outside 1..12 run for 31 days
	function automatic logic [4:0] length_of_month(input logic [3:0] m, input logic leap);
		if (m < 4'd1 || m > LAST_MONTH)
			return 5'd31;
		if (m == 4'd2 && leap)
			return 5'd29;
		return COMMON_YEAR_DAYS[m];
	endfunction

	// anything at or above its last legal value rolls over and carries
	function automatic calendar_reading_t one_second_later(input calendar_reading_t c);
		if (c.seconds < LAST_SECOND) begin
			c.seconds = c.seconds + 6'd1;
			return c;
		end
		c.seconds = 6'd0;
		if (c.minutes < LAST_MINUTE) begin
			c.minutes = c.minutes + 6'd1;
			return c;
		end
		c.minutes = 6'd0;
		if (c.hours < LAST_HOUR) begin
			c.hours = c.hours + 5'd1;
			return c;
		end
		c.hours = 5'd0;
		c.weekday = (c.weekday >= LAST_WEEKDAY) ? 3'd1 : c.weekday + 3'd1;
		if (c.day < length_of_month(c.month, c.leap)) begin
			c.day = c.day + 5'd1;
			return c;
		end
		c.day = 5'd1;
		if (c.month < LAST_MONTH) begin
			c.month = c.month + 4'd1;
			return c;
		end
		c.month = 4'd1;
		c.year = c.year + 16'd1;
		c.leap = gregorian_leap(c.year);
		return c;
	endfunction

	function automatic bit field_differs(input string name, input int want_v, input int got_v);
		if (want_v == got_v)
			return 1'b0;
		if (mismatch_count < MAX_REPORTED)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		calendar_reading_t want;
		calendar_reading_t got;
		bit bad;
		if (!arst_n) begin
			clock_state = '{16'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd1, 1'b0, 1'b1};
			expected_words.delete();
			mismatch_count = 0;
			words_outstanding = 0;
			words_checked = 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (operation == OP_LOAD)
					clock_state = '{set_year, set_month, set_day, set_hours, set_minutes,
						set_seconds, set_weekday, 1'b0, gregorian_leap(set_year)};
				else
					clock_state = one_second_later(clock_state);
				want = clock_state;
				want.pm = (clock_state.hours >= NOON_HOUR);
				expected_words.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					if (mismatch_count < MAX_REPORTED)
						$display("%0t: unexpected result word, expected none, got %0d-%0d-%0d %0d:%0d:%0d",
							$time, year_now, month_now, day_now, hours_now, minutes_now,
							seconds_now);
					mismatch_count++;
				end else begin
					want = expected_words.pop_front();
					got = '{year_now, month_now, day_now, hours_now, minutes_now, seconds_now,
						weekday_now, pm_flag, leap_flag};
					bad = 1'b0;
					bad |= field_differs("year_now", want.year, got.year);
					bad |= field_differs("month_now", want.month, got.month);
					bad |= field_differs("day_now", want.day, got.day);
					bad |= field_differs("hours_now", want.hours, got.hours);
					bad |= field_differs("minutes_now", want.minutes, got.minutes);
					bad |= field_differs("seconds_now", want.seconds, got.seconds);
					bad |= field_differs("weekday_now", want.weekday, got.weekday);
					bad |= field_differs("pm_flag", want.pm, got.pm);
					bad |= field_differs("leap_flag", want.leap, got.leap);
					if (bad)
						mismatch_count++;
					words_checked++;
				end
			end
			words_outstanding = expected_words.size();
		end
	end

endmodule

@@ tb/tb_calendar_clock_tick.sv @@
module tb_calendar_clock_tick;
	import cct_pkg::*;

	localparam int TOTAL_WORDS = 1175;
	localparam int LONG_HOLD   = 60;
	localparam int HOLD_AT     = 400;
	localparam int DRAIN_AT    = 800;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [15:0] set_year;
	logic [3:0]  set_month;
	logic [4:0]  set_day;
	logic [4:0]  set_hours;
	logic [5:0]  set_minutes;
	logic [5:0]  set_seconds;
	logic [2:0]  set_weekday;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] year_now;
	logic [3:0]  month_now;
	logic [4:0]  day_now;
	logic [4:0]  hours_now;
	logic [5:0]  minutes_now;
	logic [5:0]  seconds_now;
	logic [2:0]  weekday_now;
	logic        pm_flag;
	logic        leap_flag;

	int mismatch_count;
	int words_outstanding;
	int words_checked;
	int ticks_sent;
	int loads_sent;
	logic quiet_tx;
	logic quiet_rx;
	logic long_hold;

	calendar_clock_tick uut (.*);

	calendar_clock_tick_checker cal_check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	// bias towards leap, century and wrap-around years
	function automatic logic [15:0] pick_year();
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return 16'(4 * $urandom_range(0, 16383));
			2: return 16'(100 * $urandom_range(0, 655));
			3: return 16'(400 * $urandom_range(0, 163));
			default: return 16'hFFFF - 16'($urandom_range(0, 3));
		endcase
	endfunction

	task automatic send_word(input logic op, input logic [15:0] y, input logic [3:0] mo,
			input logic [4:0] d, input logic [4:0] h, input logic [5:0] mi,
			input logic [5:0] s, input logic [2:0] wd);
		int gap;
		gap = quiet_tx ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		set_year    <= y;
		set_month   <= mo;
		set_day     <= d;
		set_hours   <= h;
		set_minutes <= mi;
		set_seconds <= s;
		set_weekday <= wd;
		do @(posedge clk); while (!(in_valid && !in_stall));
		@(negedge clk);
		if (op == OP_LOAD)
			loads_sent++;
		else
			ticks_sent++;
	endtask

	// set fields carry junk on a tick
	task automatic send_tick();
		send_word(OP_TICK, 16'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
			6'($urandom), 6'($urandom), 3'($urandom));
	endtask

	initial begin : receiver
		int wait_cycles;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold = 1'b0;
			end
			wait_cycles = quiet_rx ? 0 : $urandom_range(0, 10);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int kind;
		bit hold_done;
		bit drain_done;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		operation   = OP_TICK;
		set_year    = '0;
		set_month   = '0;
		set_day     = '0;
		set_hours   = '0;
		set_minutes = '0;
		set_seconds = '0;
		set_weekday = '0;
		quiet_tx    = 1'b0;
		quiet_rx    = 1'b0;
		long_hold   = 1'b0;
		ticks_sent  = 0;
		loads_sent  = 0;
		hold_done   = 1'b0;
		drain_done  = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// tick out of reset, year wrap, leap rules, out-of-range loads, noon
		send_tick();
		send_word(OP_LOAD, 16'hFFFF, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd7);
		send_tick();
		send_word(OP_LOAD, 16'd2000, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 3'd2);
		send_tick();
		send_word(OP_LOAD, 16'd1900, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 3'd3);
		send_tick();
		send_word(OP_LOAD, 16'd2024, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59, 3'd4);
		send_tick();
		send_word(OP_LOAD, 16'd2023, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 3'd5);
		send_tick();
		send_word(OP_LOAD, 16'd0, 4'd0, 5'd31, 5'd31, 6'd63, 6'd63, 3'd0);
		send_tick();
		send_word(OP_LOAD, 16'd1999, 4'd15, 5'd31, 5'd23, 6'd59, 6'd59, 3'd7);
		send_tick();
		send_word(OP_LOAD, 16'd2021, 4'd4, 5'd30, 5'd23, 6'd59, 6'd59, 3'd6);
		send_tick();
		send_word(OP_LOAD, 16'd2022, 4'd6, 5'd31, 5'd23, 6'd59, 6'd59, 3'd1);
		send_tick();
		send_word(OP_LOAD, 16'd2030, 4'd7, 5'd4, 5'd11, 6'd59, 6'd59, 3'd2);
		send_tick();
		send_word(OP_LOAD, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 3'd0);
		send_tick();

		while (ticks_sent + loads_sent < TOTAL_WORDS) begin
			if (!hold_done && ticks_sent + loads_sent >= HOLD_AT) begin
				// starve the output while words keep coming back to back
				hold_done = 1'b1;
				quiet_tx = 1'b1;
				long_hold = 1'b1;
			end
			if (!drain_done && ticks_sent + loads_sent >= DRAIN_AT) begin
				drain_done = 1'b1;
				in_valid <= 1'b0;
				wait (words_outstanding == 0);
				@(negedge clk);
			end
			if (!long_hold && $urandom_range(0, 7) == 0)
				quiet_tx = ~quiet_tx;
			if ($urandom_range(0, 7) == 0)
				quiet_rx = ~quiet_rx;

			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				// load just short of a rollover, then tick across it
				send_word(OP_LOAD, pick_year(),
					($urandom_range(0, 2) == 0) ? LAST_MONTH : 4'($urandom_range(1, 12)),
					5'($urandom_range(26, 31)),
					($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 23)) : LAST_HOUR,
					($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 59)) : LAST_MINUTE,
					6'($urandom_range(48, 59)), 3'($urandom_range(1, 7)));
				repeat ($urandom_range(1, 14)) send_tick();
			end else if (kind < 80) begin
				repeat ($urandom_range(1, 30)) send_tick();
			end else if (kind < 90) begin
				send_word(OP_LOAD, pick_year(), 4'($urandom_range(1, 12)),
					5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
					6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)),
					3'($urandom_range(1, 7)));
				repeat ($urandom_range(1, 8)) send_tick();
			end else begin
				send_word(OP_LOAD, 16'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
					6'($urandom), 6'($urandom), 3'($urandom));
				repeat ($urandom_range(1, 5)) send_tick();
			end
		end
		in_valid <= 1'b0;

		wait (words_outstanding == 0);
		repeat (8) @(negedge clk);
		$display("Run covered %0d ticks and %0d loads: second to year rollovers, leap and",
			ticks_sent, loads_sent);
		$display("century years, year wrap and out-of-range loads; %0d result words checked.",
			words_checked);
		if (mismatch_count == 0 && words_outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/cct_pkg.sv
sv/calendar_clock_tick.sv
tb/calendar_clock_tick_checker.sv
tb/tb_calendar_clock_tick.sv
